### hw/rtl/hrls_pkg.sv
// Shared types and codes of the HTTP request line splitter.
`default_nettype none

package hrls_pkg;

   localparam int ByteWidth   = 8;
   localparam int TagWidth    = 3;
   localparam int StatusWidth = 2;

   // Field tags carried with each byte
   localparam logic [TagWidth-1:0] TAG_SKIP    = 3'd0;
   localparam logic [TagWidth-1:0] TAG_METHOD  = 3'd1;
   localparam logic [TagWidth-1:0] TAG_HOST    = 3'd2;
   localparam logic [TagWidth-1:0] TAG_PORT    = 3'd3;
   localparam logic [TagWidth-1:0] TAG_PATH    = 3'd4;
   localparam logic [TagWidth-1:0] TAG_HEADERS = 3'd5;

   // Request status reported on the last byte
   localparam logic [StatusWidth-1:0] STATUS_COMPLETE   = 2'd0;
   localparam logic [StatusWidth-1:0] STATUS_INCOMPLETE = 2'd1;
   localparam logic [StatusWidth-1:0] STATUS_MALFORMED  = 2'd2;

   // Delimiter bytes
   localparam logic [ByteWidth-1:0] CHAR_SPACE = 8'h20;
   localparam logic [ByteWidth-1:0] CHAR_CR    = 8'h0D;
   localparam logic [ByteWidth-1:0] CHAR_LF    = 8'h0A;
   localparam logic [ByteWidth-1:0] CHAR_SLASH = 8'h2F;
   localparam logic [ByteWidth-1:0] CHAR_COLON = 8'h3A;

   // CR LF CR LF as one word, oldest byte highest
   localparam logic [4*ByteWidth-1:0] BLANK_LINE = 32'h0D0A0D0A;

   typedef struct packed {
      logic [ByteWidth-1:0] data_byte;
      logic                 end_of_buffer;
   } req_item_type;

   typedef struct packed {
      logic [ByteWidth-1:0]   echo_byte;
      logic [TagWidth-1:0]    field_tag;
      logic                   field_first;
      logic                   uses_default_port;
      logic                   request_done;
      logic [StatusWidth-1:0] status;
   } rsp_item_type;

   // Input register contents handed to the parser
   typedef struct packed {
      logic         valid;
      req_item_type item;
   } stage_type;

endpackage

`default_nettype wire

### hw/rtl/hrls_if.sv
// Request and response channel interfaces of the HTTP request line splitter.
`default_nettype none

interface hrls_req_if;
   import hrls_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [ByteWidth-1:0] data_byte;
   logic                 end_of_buffer;

   modport source (output valid, output data_byte, output end_of_buffer, input ready);
   modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface hrls_rsp_if;
   import hrls_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [ByteWidth-1:0]   echo_byte;
   logic [TagWidth-1:0]    field_tag;
   logic                   field_first;
   logic                   uses_default_port;
   logic                   request_done;
   logic [StatusWidth-1:0] status;

   modport source (
      output valid, output echo_byte, output field_tag, output field_first,
      output uses_default_port, output request_done, output status, input ready
   );
   modport sink (
      input valid, input echo_byte, input field_tag, input field_first,
      input uses_default_port, input request_done, input status, output ready
   );
endinterface

`default_nettype wire

### hw/rtl/hrls_input_stage.sv
// Input register of the HTTP request line splitter.
`default_nettype none

module hrls_input_stage (
   input  wire logic        clock,
   input  wire logic        reset,
   hrls_req_if.sink         req_in,
   input  wire logic        take,
   output hrls_pkg::stage_type stage
);
   import hrls_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   logic         load;

   // accept when empty or when the held item moves on this cycle
   assign req_in.ready = !valid_ff || take;
   assign load         = req_in.valid && req_in.ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         item_ff.data_byte     <= req_in.data_byte;
         item_ff.end_of_buffer <= req_in.end_of_buffer;
      end
   end

   assign stage.valid = valid_ff;
   assign stage.item  = item_ff;

endmodule

`default_nettype wire

### hw/rtl/hrls_parser.sv
// Per-byte field tagging and request status logic with its parse state.
`default_nettype none

module hrls_parser (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire hrls_pkg::stage_type stage,
   input  wire logic              take,
   output hrls_pkg::rsp_item_type result
);
   import hrls_pkg::*;

   typedef enum logic [2:0] {
      PH_METHOD   = 3'd0,
      PH_SEEK     = 3'd1,
      PH_HOST     = 3'd2,
      PH_PORT     = 3'd3,
      PH_PATH     = 3'd4,
      PH_LINE_END = 3'd5,
      PH_HEADERS  = 3'd6,
      PH_BAD      = 3'd7
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [3*ByteWidth-1:0] recent_ff, recent_in;
   logic                   blank_ff, blank_in;
   logic                   open_ff, open_in;

   logic [ByteWidth-1:0]   b;
   logic [ByteWidth-1:0]   prev;
   logic                   last;
   logic                   crlf;
   logic [4*ByteWidth-1:0] window;
   logic [TagWidth-1:0]    tag;
   logic                   dflt;
   logic                   fire;
   logic                   line_short;

   assign b      = stage.item.data_byte;
   assign last   = stage.item.end_of_buffer;
   assign prev   = recent_ff[ByteWidth-1:0];
   assign crlf   = (b == CHAR_LF) && (prev == CHAR_CR);
   assign window = {recent_ff, b};
   assign fire   = stage.valid && take;

   always_comb begin
      tag      = TAG_SKIP;
      phase_in = phase_ff;
      dflt     = 1'b0;
      case (phase_ff)
         PH_METHOD: begin
            if (b == CHAR_SPACE) phase_in = PH_SEEK;
            else if (crlf)       phase_in = PH_BAD;
            else                 tag = TAG_METHOD;
         end
         PH_SEEK: begin
            if (b == CHAR_SLASH && prev == CHAR_SLASH) phase_in = PH_HOST;
            else if (crlf)                             phase_in = PH_BAD;
         end
         PH_HOST: begin
            if (b == CHAR_SLASH) begin
               phase_in = PH_PATH;
               dflt     = 1'b1;
            end else if (b == CHAR_COLON) phase_in = PH_PORT;
            else if (crlf)                phase_in = PH_BAD;
            else                          tag = TAG_HOST;
         end
         PH_PORT: begin
            if (b == CHAR_SLASH) phase_in = PH_PATH;
            else if (crlf)       phase_in = PH_BAD;
            else                 tag = TAG_PORT;
         end
         PH_PATH: begin
            if (b == CHAR_SPACE || b == CHAR_CR) phase_in = PH_LINE_END;
            else                                 tag = TAG_PATH;
         end
         PH_LINE_END: begin
            if (crlf) phase_in = PH_HEADERS;
         end
         PH_HEADERS: begin
            tag = TAG_HEADERS;
         end
         default: begin
         end
      endcase
   end

   // path never reached, or line ended early
   assign line_short = (phase_in == PH_METHOD) || (phase_in == PH_SEEK) ||
                       (phase_in == PH_HOST) || (phase_in == PH_PORT) ||
                       (phase_in == PH_BAD);

   assign blank_in  = blank_ff || (window == BLANK_LINE);
   assign recent_in = window[3*ByteWidth-1:0];
   assign open_in   = (phase_in == phase_ff) ? (open_ff || (tag != TAG_SKIP)) : 1'b0;

   always_comb begin
      result.echo_byte         = b;
      result.field_tag         = tag;
      result.field_first       = (tag != TAG_SKIP) && !open_ff;
      result.uses_default_port = dflt;
      result.request_done      = last;
      if (!last)          result.status = STATUS_COMPLETE;
      else if (!blank_in) result.status = STATUS_INCOMPLETE;
      else if (line_short) result.status = STATUS_MALFORMED;
      else                result.status = STATUS_COMPLETE;
   end

   // advance the state per byte; drop back to the start after the last byte
   always_ff @(posedge clock) begin
      if (reset || (fire && last)) begin
         phase_ff  <= PH_METHOD;
         recent_ff <= '0;
         blank_ff  <= 1'b0;
         open_ff   <= 1'b0;
      end else if (fire) begin
         phase_ff  <= phase_in;
         recent_ff <= recent_in;
         blank_ff  <= blank_in;
         open_ff   <= open_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/hrls_output_stage.sv
// Result register of the HTTP request line splitter.
`default_nettype none

module hrls_output_stage (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 valid,
   input  wire hrls_pkg::rsp_item_type result,
   hrls_rsp_if.source                rsp_out,
   output logic                      take
);
   import hrls_pkg::*;

   logic         valid_ff;
   rsp_item_type item_ff;

   // the register frees up when empty or when its item is taken now
   assign take = !valid_ff || rsp_out.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (take) begin
         valid_ff <= valid;
      end
      if (take && valid) begin
         item_ff <= result;
      end
   end

   assign rsp_out.valid             = valid_ff;
   assign rsp_out.echo_byte         = item_ff.echo_byte;
   assign rsp_out.field_tag         = item_ff.field_tag;
   assign rsp_out.field_first       = item_ff.field_first;
   assign rsp_out.uses_default_port = item_ff.uses_default_port;
   assign rsp_out.request_done      = item_ff.request_done;
   assign rsp_out.status            = item_ff.status;

endmodule

`default_nettype wire

### hw/rtl/http_request_line_splitter.sv
// Top level of the HTTP request line splitter.
//
//   channel  dir  handshake    payload
//   req_in   in   valid/ready  data_byte[7:0], end_of_buffer
//   rsp_out  out  valid/ready  echo_byte[7:0], field_tag[2:0], field_first,
//                              uses_default_port, request_done, status[1:0]
//
// One item in, one item out. An accepted byte sits in the input register,
// the parser tags it as it moves into the result register, and the result is
// then valid on rsp_out; a new byte is taken every cycle while rsp_out does
// not stall.
// The parse state advances only when a byte moves into the result register,
// which keeps byte order intact under any stall pattern.
// Synchronous active-high reset empties both registers and returns the parse
// state to the method phase; the last byte of a buffer, as it moves on, also
// returns the parse state there. A stall on rsp_out holds the result register
// and deasserts req_in.ready once the input register holds a byte.
`default_nettype none

module http_request_line_splitter (
   input  wire logic clock,
   input  wire logic reset,
   hrls_req_if.sink   req_in,
   hrls_rsp_if.source rsp_out
);
   import hrls_pkg::*;

   stage_type    stage;
   rsp_item_type result;
   logic         take;

   // hold each accepted byte until the result register can receive it
   hrls_input_stage u_input (
      .clock  (clock),
      .reset  (reset),
      .req_in (req_in),
      .take   (take),
      .stage  (stage)
   );

   // tag the held byte and advance the parse state as it moves on
   hrls_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .stage  (stage),
      .take   (take),
      .result (result)
   );

   // hold the tagged byte until the consumer takes it
   hrls_output_stage u_output (
      .clock   (clock),
      .reset   (reset),
      .valid   (stage.valid),
      .result  (result),
      .rsp_out (rsp_out),
      .take    (take)
   );

endmodule

`default_nettype wire

### tb/http_request_line_splitter_test.sv
// Self-checking testbench of the HTTP request line splitter.
`timescale 1ns / 1ps
`default_nettype none

module http_request_line_splitter_test;
   import hrls_pkg::*;

   localparam int ClockPeriod  = 10;
   localparam int ResetCycles  = 5;
   localparam int RandomBytes  = 1600;
   localparam int StallLimit   = 500;   // cycles with no item moving on either side
   localparam int TailCycles   = 10;    // margin for late or extra results after the drain
   localparam int MaxPrinted   = 200;   // keep the log short on a badly broken block

   // Parse phases of the splitter, in the order the fields appear
   typedef enum logic [2:0] {
      PHASE_METHOD,
      PHASE_SEEK,
      PHASE_HOST,
      PHASE_PORT,
      PHASE_PATH,
      PHASE_LINE_END,
      PHASE_HEADERS,
      PHASE_BAD
   } phase_type;

   logic clock = 1'b0;
   logic reset;

   hrls_req_if req_in ();
   hrls_rsp_if rsp_out ();

   http_request_line_splitter i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_in  (req_in),
      .rsp_out (rsp_out)
   );

   always #(ClockPeriod / 2) clock = ~clock;

   // Own copy of the parse state, advanced once per accepted item
   phase_type    parse_phase;
   logic [23:0]  last_three_bytes;   // newest byte lowest
   logic         saw_blank_line;
   logic         field_started;

   rsp_item_type expected_tags[$];   // tagged bytes still owed by the block
   rsp_item_type oldest_tags;
   logic [7:0]   request_bytes[$];   // request being assembled for sending

   int  mismatch_count = 0;
   int  sent_bytes     = 0;
   int  quiet_cycles   = 0;
   bit  sender_idles   = 1'b1;
   bit  receiver_stalls = 1'b1;

   task automatic report_mismatch(input string what, input logic [7:0] expected,
                                  input logic [7:0] actual);
      mismatch_count++;
      if (mismatch_count <= MaxPrinted)
         $display("%0t: mismatch on %s: expected %h, got %h", $realtime, what, expected, actual);
   endtask

   function automatic void clear_parse_state();
      parse_phase      = PHASE_METHOD;
      last_three_bytes = '0;
      saw_blank_line   = 1'b0;
      field_started    = 1'b0;
   endfunction

   // Tag one byte and advance the parse state
   function automatic rsp_item_type tag_byte(input req_item_type item);
      rsp_item_type tag_result;
      phase_type    next_phase;
      logic [7:0]   b;
      logic [7:0]   prev;
      logic         crlf;
      logic         blank;
      logic [31:0]  window;
      logic [2:0]   tag;
      logic         default_port;

      b            = item.data_byte;
      prev         = last_three_bytes[7:0];
      crlf         = (b == CHAR_LF) && (prev == CHAR_CR);
      window       = {last_three_bytes, b};
      tag          = TAG_SKIP;
      next_phase   = parse_phase;
      default_port = 1'b0;

      case (parse_phase)
         PHASE_METHOD: begin
            if (b == CHAR_SPACE) next_phase = PHASE_SEEK;
            else if (crlf) next_phase = PHASE_BAD;
            else tag = TAG_METHOD;
         end
         PHASE_SEEK: begin
            if (b == CHAR_SLASH && prev == CHAR_SLASH) next_phase = PHASE_HOST;
            else if (crlf) next_phase = PHASE_BAD;
         end
         PHASE_HOST: begin
            if (b == CHAR_SLASH) begin
               next_phase   = PHASE_PATH;
               default_port = 1'b1;
            end else if (b == CHAR_COLON) next_phase = PHASE_PORT;
            else if (crlf) next_phase = PHASE_BAD;
            else tag = TAG_HOST;
         end
         PHASE_PORT: begin
            if (b == CHAR_SLASH) next_phase = PHASE_PATH;
            else if (crlf) next_phase = PHASE_BAD;
            else tag = TAG_PORT;
         end
         PHASE_PATH: begin
            // a carriage return ends the path just like a space
            if (b == CHAR_SPACE || b == CHAR_CR) next_phase = PHASE_LINE_END;
            else tag = TAG_PATH;
         end
         PHASE_LINE_END: begin
            if (crlf) next_phase = PHASE_HEADERS;
         end
         PHASE_HEADERS: tag = TAG_HEADERS;
         default: ;
      endcase

      blank = saw_blank_line || (window == BLANK_LINE);

      tag_result.echo_byte         = b;
      tag_result.field_tag         = tag;
      tag_result.field_first       = (tag != TAG_SKIP) && !field_started;
      tag_result.uses_default_port = default_port;
      tag_result.request_done      = item.end_of_buffer;
      if (!item.end_of_buffer) tag_result.status = STATUS_COMPLETE;
      else if (!blank) tag_result.status = STATUS_INCOMPLETE;
      else if (next_phase < PHASE_PATH || next_phase == PHASE_BAD)
         tag_result.status = STATUS_MALFORMED;
      else tag_result.status = STATUS_COMPLETE;

      if (item.end_of_buffer) begin
         clear_parse_state();
      end else begin
         field_started    = (next_phase == parse_phase) ? (field_started || tag != TAG_SKIP)
                                                        : 1'b0;
         parse_phase      = next_phase;
         last_three_bytes = window[23:0];
         saw_blank_line   = blank;
      end
      return tag_result;
   endfunction

   // Send one item: idle for a drawn number of cycles, hold valid until taken.
   // Valid stays high straight into the next item when no gap is drawn.
   task automatic send_byte(input logic [7:0] b, input logic last);
      int           gap;
      req_item_type item;

      gap = sender_idles ? $urandom_range(0, 7) : 0;
      if (gap != 0) begin
         req_in.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_in.valid         <= 1'b1;
      req_in.data_byte     <= b;
      req_in.end_of_buffer <= last;
      do @(posedge clock); while (req_in.ready !== 1'b1);
      item.data_byte     = b;
      item.end_of_buffer = last;
      expected_tags.push_back(tag_byte(item));
      sent_bytes++;
      @(negedge clock);
   endtask

   task automatic send_text(input string text, input logic ends_buffer);
      for (int i = 0; i < text.len(); i++)
         send_byte(text[i], ends_buffer && (i == text.len() - 1));
   endtask

   task automatic send_request();
      foreach (request_bytes[i])
         send_byte(request_bytes[i], i == request_bytes.size() - 1);
   endtask

   // Drop valid and hold off until the block has returned everything owed
   task automatic wait_for_results();
      req_in.valid <= 1'b0;
      while (expected_tags.size() != 0) @(negedge clock);
   endtask

   // Any byte but the delimiters, so that a field keeps going
   function automatic logic [7:0] pick_content_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while (b inside {CHAR_SPACE, CHAR_CR, CHAR_LF, CHAR_SLASH, CHAR_COLON});
      return b;
   endfunction

   function automatic void add_content(input int count);
      repeat (count) request_bytes.push_back(pick_content_byte());
   endfunction

   function automatic void add_crlf();
      request_bytes.push_back(CHAR_CR);
      request_bytes.push_back(CHAR_LF);
   endfunction

   // Assemble a request line plus headers with random field contents
   function automatic void build_request();
      request_bytes.delete();
      add_content($urandom_range(0, 4));               // method
      request_bytes.push_back(CHAR_SPACE);
      add_content($urandom_range(0, 3));               // scheme junk before the slashes
      request_bytes.push_back(CHAR_SLASH);
      request_bytes.push_back(CHAR_SLASH);
      add_content($urandom_range(0, 5));               // host
      if ($urandom_range(0, 1) == 1) begin
         request_bytes.push_back(CHAR_COLON);
         add_content($urandom_range(0, 3));            // port
      end
      request_bytes.push_back(CHAR_SLASH);
      add_content($urandom_range(0, 6));               // path
      request_bytes.push_back($urandom_range(0, 1) == 1 ? CHAR_SPACE : CHAR_CR);
      add_content($urandom_range(0, 4));               // version
      add_crlf();
      repeat ($urandom_range(0, 2)) begin
         add_content($urandom_range(1, 6));            // header line
         add_crlf();
      end
      if ($urandom_range(0, 4) != 0) add_crlf();       // blank line ends the headers
      add_content($urandom_range(0, 3));               // trailing body bytes
   endfunction

   // Full request with an extreme byte value in each of method, host, port and path
   task automatic test_full_request_with_port();
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_text(" //", 1'b0);
      send_byte(8'hFF, 1'b0);
      send_text(":", 1'b0);
      send_byte(8'h00, 1'b0);
      send_text("/", 1'b0);
      send_byte(8'hFF, 1'b0);
      send_text(" \r\n\r\n", 1'b1);
   endtask

   // Empty method and host, default port, path ended by CR, no blank line
   task automatic test_empty_fields();
      send_text(" ///\r", 1'b1);
   endtask

   // Line ends before the path begins: malformed even with a blank line
   task automatic test_early_line_end();
      send_text("\r\n\r\n", 1'b1);
   endtask

   task automatic test_random_requests();
      int kind;
      int keep;
      int pos;

      while (sent_bytes < RandomBytes) begin
         kind = $urandom_range(0, 9);
         if (kind == 0) begin
            // noise: arbitrary bytes
            request_bytes.delete();
            repeat ($urandom_range(1, 12)) request_bytes.push_back(8'($urandom_range(0, 255)));
         end else begin
            build_request();
            if (kind == 1) begin
               // broken line: a stray CRLF anywhere
               pos = $urandom_range(0, request_bytes.size() - 1);
               request_bytes.insert(pos, CHAR_LF);
               request_bytes.insert(pos, CHAR_CR);
            end
         end
         // cut the buffer short now and then
         if ($urandom_range(0, 4) == 0) begin
            keep = $urandom_range(1, request_bytes.size());
            while (request_bytes.size() > keep) void'(request_bytes.pop_back());
         end
         sender_idles    = $urandom_range(0, 3) != 0;
         receiver_stalls = $urandom_range(0, 3) != 0;
         send_request();
         if ($urandom_range(0, 9) == 0) wait_for_results();
      end
   endtask

   // Receiver: draw a stall for every item, then hold ready until it is taken
   initial begin
      int stall;

      rsp_out.ready = 1'b0;
      @(negedge clock);
      forever begin
         stall = receiver_stalls ? $urandom_range(0, 7) : 0;
         if (stall != 0) begin
            rsp_out.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_out.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_out.valid === 1'b1 && reset === 1'b0));
         @(negedge clock);
      end
   end

   // Compare every accepted result with the oldest expectation
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_out.valid === 1'b1 && rsp_out.ready === 1'b1) begin
         if (expected_tags.size() == 0) begin
            report_mismatch("result with nothing expected", 8'h00, rsp_out.echo_byte);
         end else begin
            oldest_tags = expected_tags.pop_front();
            if (rsp_out.echo_byte !== oldest_tags.echo_byte)
               report_mismatch("echo_byte", oldest_tags.echo_byte, rsp_out.echo_byte);
            if (rsp_out.field_tag !== oldest_tags.field_tag)
               report_mismatch("field_tag", 8'(oldest_tags.field_tag),
                               8'(rsp_out.field_tag));
            if (rsp_out.field_first !== oldest_tags.field_first)
               report_mismatch("field_first", 8'(oldest_tags.field_first),
                               8'(rsp_out.field_first));
            if (rsp_out.uses_default_port !== oldest_tags.uses_default_port)
               report_mismatch("uses_default_port", 8'(oldest_tags.uses_default_port),
                               8'(rsp_out.uses_default_port));
            if (rsp_out.request_done !== oldest_tags.request_done)
               report_mismatch("request_done", 8'(oldest_tags.request_done),
                               8'(rsp_out.request_done));
            if (rsp_out.status !== oldest_tags.status)
               report_mismatch("status", 8'(oldest_tags.status), 8'(rsp_out.status));
         end
      end
   end

   // Watchdog: end the run when no item has moved for too long
   always @(posedge clock) begin
      if ((req_in.valid === 1'b1 && req_in.ready === 1'b1) ||
          (rsp_out.valid === 1'b1 && rsp_out.ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset                = 1'b1;
      req_in.valid         = 1'b0;
      req_in.data_byte     = '0;
      req_in.end_of_buffer = 1'b0;
      clear_parse_state();
      repeat (ResetCycles) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_full_request_with_port();
      test_empty_fields();
      wait_for_results();
      test_early_line_end();
      wait_for_results();
      test_random_requests();

      // drain, then give late or extra results a chance to show up
      wait_for_results();
      repeat (TailCycles) @(negedge clock);
      if (expected_tags.size() != 0)
         report_mismatch("results never returned", 8'(expected_tags.size()), 8'h00);

      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

### filelist.f
hw/rtl/hrls_pkg.sv
hw/rtl/hrls_if.sv
hw/rtl/hrls_input_stage.sv
hw/rtl/hrls_parser.sv
hw/rtl/hrls_output_stage.sv
hw/rtl/http_request_line_splitter.sv
tb/http_request_line_splitter_test.sv
